// ===== hw/rtl/chb_pkg.sv =====
package chb_pkg;

    // Pool geometry
    localparam int CHUNK_WORDS = 16;
    localparam int CHUNK_COUNT = 3;
    localparam int RING_DEPTH  = 5;

    localparam int CHUNK_W     = $clog2(CHUNK_COUNT);
    localparam int POS_W       = $clog2(CHUNK_WORDS);
    localparam int RING_W      = $clog2(RING_DEPTH);
    localparam int FILL_W      = $clog2(RING_DEPTH + 1);
    localparam int COUNT_W     = $clog2(CHUNK_COUNT + 1);
    localparam int STORE_DEPTH = CHUNK_COUNT * CHUNK_WORDS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Result queue behind the store read stage
    localparam int QDEPTH = 3;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Access kinds and status codes
    localparam logic FUNC_WRITE     = 1'b0;
    localparam logic FUNC_READ      = 1'b1;
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_BLOCKED = 1'b1;

    typedef logic signed [31:0] word_t;
    typedef logic [CHUNK_W-1:0] chunk_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [RING_W-1:0]  ring_idx_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    // Command to the chunk store
    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        addr_t addr;
        word_t wdata;
    } mem_cmd_t;

    // Per-access outcome handed to the result side
    typedef struct packed {
        logic valid;
        logic status;
        logic closed;
        logic is_read;
    } issue_t;

    // One queued result
    typedef struct packed {
        logic  status;
        word_t word;
        logic  closed;
    } result_t;

    function automatic ring_idx_t ring_inc(input ring_idx_t idx);
        ring_idx_t nxt;
        if (idx == RING_W'(RING_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

    function automatic addr_t word_addr(input chunk_t chunk, input pos_t pos);
        addr_t a;
        a = ADDR_W'(chunk) * ADDR_W'(CHUNK_WORDS) + ADDR_W'(pos);
        return a;
    endfunction

endpackage

// ===== hw/rtl/chb_if.sv =====
// Access request channel
interface chb_req_if;
    logic          valid;
    logic          ready;
    logic          func;
    chb_pkg::word_t write_word;

    modport source (output valid, output func, output write_word, input ready);
    modport sink   (input valid, input func, input write_word, output ready);
endinterface

// Access result channel
interface chb_rsp_if;
    logic          valid;
    logic          ready;
    logic          status;
    chb_pkg::word_t read_word;
    logic          chunk_closed;

    modport source (output valid, output status, output read_word, output chunk_closed,
                    input ready);
    modport sink   (input valid, input status, input read_word, input chunk_closed,
                    output ready);
endinterface

// ===== hw/rtl/chb_ctrl.sv =====
module chb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              func,
    input  chb_pkg::word_t    write_word,
    output chb_pkg::mem_cmd_t cmd,
    output chb_pkg::issue_t   issue
);

    chb_pkg::chunk_t                free_link_reg [chb_pkg::CHUNK_COUNT];
    chb_pkg::chunk_t                ready_ring_reg [chb_pkg::RING_DEPTH];

    chb_pkg::chunk_t                free_head_reg, free_head_next;
    logic [chb_pkg::COUNT_W-1:0]    free_len_reg, free_len_next;
    logic [chb_pkg::COUNT_W-1:0]    handed_reg, handed_next;
    chb_pkg::ring_idx_t             ring_head_reg, ring_head_next;
    chb_pkg::ring_idx_t             ring_tail_reg, ring_tail_next;
    logic [chb_pkg::FILL_W-1:0]     ring_fill_reg, ring_fill_next;
    chb_pkg::chunk_t                writer_chunk_reg, writer_chunk_next;
    logic                           writer_active_reg, writer_active_next;
    chb_pkg::pos_t                  writer_pos_reg, writer_pos_next;
    chb_pkg::chunk_t                reader_chunk_reg, reader_chunk_next;
    logic                           reader_active_reg, reader_active_next;
    chb_pkg::pos_t                  reader_pos_reg, reader_pos_next;

    logic                           link_we;
    logic                           ring_we;

    // Decide the access and the next pool state
    always_comb
    begin
        chb_pkg::chunk_t w_chunk;
        chb_pkg::pos_t   w_pos;
        logic            w_ok;
        logic            w_last;
        logic            from_free;
        logic            from_new;
        chb_pkg::chunk_t r_chunk;
        chb_pkg::pos_t   r_pos;
        logic            r_last;

        free_head_next     = free_head_reg;
        free_len_next      = free_len_reg;
        handed_next        = handed_reg;
        ring_head_next     = ring_head_reg;
        ring_tail_next     = ring_tail_reg;
        ring_fill_next     = ring_fill_reg;
        writer_chunk_next  = writer_chunk_reg;
        writer_active_next = writer_active_reg;
        writer_pos_next    = writer_pos_reg;
        reader_chunk_next  = reader_chunk_reg;
        reader_active_next = reader_active_reg;
        reader_pos_next    = reader_pos_reg;
        link_we            = 1'b0;
        ring_we            = 1'b0;

        cmd.wr_en  = 1'b0;
        cmd.rd_en  = 1'b0;
        cmd.addr   = '0;
        cmd.wdata  = write_word;

        issue.valid   = accept;
        issue.status  = chb_pkg::STATUS_BLOCKED;
        issue.closed  = 1'b0;
        issue.is_read = (func == chb_pkg::FUNC_READ);

        w_chunk   = writer_chunk_reg;
        w_pos     = writer_pos_reg;
        w_ok      = 1'b1;
        from_free = 1'b0;
        from_new  = 1'b0;
        r_chunk   = reader_chunk_reg;
        r_pos     = reader_pos_reg;

        // Write: take a chunk if none is open, then store one word
        if (!writer_active_reg) begin
            if (free_len_reg != '0) begin
                w_chunk   = free_head_reg;
                from_free = 1'b1;
            end else if (handed_reg < chb_pkg::COUNT_W'(chb_pkg::CHUNK_COUNT)) begin
                w_chunk  = handed_reg[chb_pkg::CHUNK_W-1:0];
                from_new = 1'b1;
            end else begin
                w_ok = 1'b0;
            end
            w_pos = '0;
        end
        w_last = (w_pos == chb_pkg::POS_W'(chb_pkg::CHUNK_WORDS - 1));
        if (w_last && ring_fill_reg == chb_pkg::FILL_W'(chb_pkg::RING_DEPTH)) begin
            w_ok = 1'b0;
        end

        // Read: open the oldest ready chunk if none is open
        if (!reader_active_reg) begin
            r_chunk = ready_ring_reg[ring_head_reg];
            r_pos   = '0;
        end
        r_last = (r_pos == chb_pkg::POS_W'(chb_pkg::CHUNK_WORDS - 1));

        if (accept && func == chb_pkg::FUNC_WRITE && w_ok) begin
            issue.status = chb_pkg::STATUS_DONE;
            cmd.wr_en    = 1'b1;
            cmd.addr     = chb_pkg::word_addr(w_chunk, w_pos);
            if (from_free) begin
                free_head_next = free_link_reg[w_chunk];
                free_len_next  = free_len_reg - 1'b1;
            end
            if (from_new) begin
                handed_next = handed_reg + 1'b1;
            end
            writer_chunk_next = w_chunk;
            if (w_last) begin
                ring_we            = 1'b1;
                ring_tail_next     = chb_pkg::ring_inc(ring_tail_reg);
                ring_fill_next     = ring_fill_reg + 1'b1;
                writer_active_next = 1'b0;
                writer_pos_next    = '0;
                issue.closed       = 1'b1;
            end else begin
                writer_active_next = 1'b1;
                writer_pos_next    = w_pos + 1'b1;
            end
        end

        if (accept && func == chb_pkg::FUNC_READ
            && (reader_active_reg || ring_fill_reg != '0)) begin
            issue.status = chb_pkg::STATUS_DONE;
            cmd.rd_en    = 1'b1;
            cmd.addr     = chb_pkg::word_addr(r_chunk, r_pos);
            if (!reader_active_reg) begin
                ring_head_next = chb_pkg::ring_inc(ring_head_reg);
                ring_fill_next = ring_fill_reg - 1'b1;
            end
            reader_chunk_next = r_chunk;
            if (r_last) begin
                link_we            = 1'b1;
                free_head_next     = r_chunk;
                free_len_next      = free_len_reg + 1'b1;
                reader_active_next = 1'b0;
                reader_pos_next    = '0;
                issue.closed       = 1'b1;
            end else begin
                reader_active_next = 1'b1;
                reader_pos_next    = r_pos + 1'b1;
            end
        end
    end

    // Advance the pool state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            free_head_reg     <= '0;
            free_len_reg      <= '0;
            handed_reg        <= '0;
            ring_head_reg     <= '0;
            ring_tail_reg     <= '0;
            ring_fill_reg     <= '0;
            writer_chunk_reg  <= '0;
            writer_active_reg <= 1'b0;
            writer_pos_reg    <= '0;
            reader_chunk_reg  <= '0;
            reader_active_reg <= 1'b0;
            reader_pos_reg    <= '0;
        end else begin
            free_head_reg     <= free_head_next;
            free_len_reg      <= free_len_next;
            handed_reg        <= handed_next;
            ring_head_reg     <= ring_head_next;
            ring_tail_reg     <= ring_tail_next;
            ring_fill_reg     <= ring_fill_next;
            writer_chunk_reg  <= writer_chunk_next;
            writer_active_reg <= writer_active_next;
            writer_pos_reg    <= writer_pos_next;
            reader_chunk_reg  <= reader_chunk_next;
            reader_active_reg <= reader_active_next;
            reader_pos_reg    <= reader_pos_next;
        end
    end

    // Link a freed chunk and queue a full one; no reset, written before read
    always_ff @(posedge clk)
    begin
        if (link_we) begin
            free_link_reg[reader_chunk_next] <= free_head_reg;
        end
        if (ring_we) begin
            ready_ring_reg[ring_tail_reg] <= writer_chunk_next;
        end
    end

endmodule

// ===== hw/rtl/chb_store.sv =====
module chb_store (
    input  logic              clk,
    input  chb_pkg::mem_cmd_t cmd,
    output chb_pkg::word_t    rdata
);

    chb_pkg::word_t mem [chb_pkg::STORE_DEPTH];
    chb_pkg::word_t rdata_reg;

    // Write one word or read one word into the output register
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en) begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/chb_outq.sv =====
module chb_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  chb_pkg::issue_t issue,
    input  chb_pkg::word_t  rdata,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output chb_pkg::result_t out_data
);

    chb_pkg::result_t            q_reg [chb_pkg::QDEPTH];
    logic                        p_valid_reg;
    logic                        p_status_reg;
    logic                        p_closed_reg;
    logic                        p_is_read_reg;
    logic [chb_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [chb_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [chb_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic [chb_pkg::QCNT_W:0]    occupancy;
    logic                        push;
    logic                        pop;
    chb_pkg::result_t            push_data;

    // Accept only while every in-flight access has a queue slot
    assign occupancy = {1'b0, cnt_reg} + {{chb_pkg::QCNT_W{1'b0}}, p_valid_reg};
    assign room      = (occupancy < (chb_pkg::QCNT_W + 1)'(chb_pkg::QDEPTH));

    assign push = p_valid_reg;
    assign pop  = out_valid && out_ready;

    // Merge the store data into the result of a completed read
    always_comb
    begin
        push_data.status = p_status_reg;
        push_data.closed = p_closed_reg;
        if (p_is_read_reg && p_status_reg == chb_pkg::STATUS_DONE) begin
            push_data.word = rdata;
        end else begin
            push_data.word = '0;
        end
    end

    // Advance queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            if (wr_ptr_reg == chb_pkg::QPTR_W'(chb_pkg::QDEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (pop) begin
            if (rd_ptr_reg == chb_pkg::QPTR_W'(chb_pkg::QDEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p_valid_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
        end else begin
            p_valid_reg <= issue.valid;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Hold the access outcome while the store read completes
    always_ff @(posedge clk)
    begin
        p_status_reg  <= issue.status;
        p_closed_reg  <= issue.closed;
        p_is_read_reg <= issue.is_read;
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/chunked_buffer_channel.sv =====
// A result passes the store read register and then the result queue before it is offered.
// Throughput: one access per cycle while ready is high; the pool state updates in the transfer cycle.
// A three-entry result queue after the store read register keeps ready high
// while at most two results are queued or in flight.
// Reset (rst_n low, asynchronous) empties the pool, ring and queue; the chunk
// store, free links and ring slots are not cleared and are written before use.
module chunked_buffer_channel (
    input  logic            clk,
    input  logic            rst_n,
    chb_req_if.sink         req,
    chb_rsp_if.source       rsp
);

    chb_pkg::mem_cmd_t  cmd;
    chb_pkg::issue_t    issue;
    chb_pkg::word_t     rdata;
    chb_pkg::result_t   out_data;
    logic               room;
    logic               accept;

    assign req.ready = room;
    assign accept    = req.valid && room;

    chb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (req.func),
        .write_word (req.write_word),
        .cmd        (cmd),
        .issue      (issue)
    );

    chb_store u_store (
        .clk   (clk),
        .cmd   (cmd),
        .rdata (rdata)
    );

    chb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .rdata     (rdata),
        .room      (room),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (out_data)
    );

    assign rsp.status       = out_data.status;
    assign rsp.read_word    = out_data.word;
    assign rsp.chunk_closed = out_data.closed;

endmodule

// ===== hw/rtl/chb_checker.sv =====
module chb_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input logic           rsp_status,
    input chb_pkg::word_t rsp_read_word,
    input logic           rsp_chunk_closed
);

    logic [2:0] outstanding_reg;
    logic       req_xfer;
    logic       rsp_xfer;

    assign req_xfer = req_valid && req_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    // Track accesses whose results are not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            outstanding_reg <= '0;
        end else if (req_xfer && !rsp_xfer) begin
            outstanding_reg <= outstanding_reg + 1'b1;
        end else if (rsp_xfer && !req_xfer) begin
            outstanding_reg <= outstanding_reg - 1'b1;
        end
    end

    // A stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_read_word) && $stable(rsp_chunk_closed))
        else $error("stalled result changed");

    // A blocked access returns no word and closes no chunk
    a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |-> rsp_read_word == 0 && !rsp_chunk_closed)
        else $error("blocked result carries data");

    // No result without an access in flight
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 0)
        else $error("result with no pending access");

    // Ready drops before more than three accesses are in flight
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 3 && !rsp_xfer |-> !req_ready)
        else $error("too many accesses in flight");

    // An idle channel offers no result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 0 && !req_xfer |=> !rsp_valid)
        else $error("result appeared too early");

endmodule

bind chunked_buffer_channel chb_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_read_word    (rsp.read_word),
    .rsp_chunk_closed (rsp.chunk_closed)
);
